>>> rtl/core/fixed_point_alu_rounding_top_assert.svh
// ----------------------------------------------------------------------------
// fixed point alu assertion macros
// concurrent assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_ROUNDING_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_ROUNDING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FPAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/fpar_pkg.sv
// ----------------------------------------------------------------------------
// fixed point alu package
// shared types, codes and widths
// ----------------------------------------------------------------------------
package fpar_pkg;

  localparam int MW = 32;
  localparam int QW = 2 * MW - 1;
  localparam int WW = $clog2(MW + 1);
  localparam int FW = $clog2(MW);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RND_ZERO    = 2'd0,
    RND_NEAREST = 2'd1,
    RND_POS     = 2'd2,
    RND_NEG     = 2'd3
  } rnd_e;

  localparam logic [1:0] REG_INT  = 2'd0;
  localparam logic [1:0] REG_FRAC = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  typedef struct packed {
    logic [WW-1:0] width;
    logic [FW-1:0] frac;
    logic [FW-1:0] msb;
    logic [MW-1:0] mask;
    rnd_e          mode;
  } fmt_t;

  typedef struct packed {
    logic          valid;
    cmd_e          cmd;
    logic          neg;
    logic [MW-1:0] rem;
    logic [QW-1:0] nq;
    logic [MW-1:0] divisor;
  } cell_t;

endpackage

>>> rtl/core/fixed_point_alu_rounding_top.sv
// ----------------------------------------------------------------------------
// fixed point alu with rounding modes
// add, subtract, multiply and divide on signed fixed-point codes
// ----------------------------------------------------------------------------
//  channel  signals                                 direction
//  in       in_valid_i in_ready_o cmd_i operand_*_i  into the block
//  out      out_valid_o out_ready_i result_code_o    out of the block
//           div_by_zero_o
//  cfg      psel penable pwrite paddr pwdata prdata   register access
//
//  one item per cycle while the pipe advances, 67 register stages:
//  two front stages, 63 divider cells (one quotient bit each),
//  two rounding stages
//  the whole pipe advances only while the output register is empty or taken
//  reset empties the pipe and loads int_bits 16, frac_bits 16, mode 0
// ----------------------------------------------------------------------------
`include "fixed_point_alu_rounding_top_assert.svh"

module fixed_point_alu_rounding_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_code_o,
  output logic        div_by_zero_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fpar_pkg::*;

  logic [5:0]    int_bits_q;
  logic [4:0]    frac_bits_q;
  logic [1:0]    mode_q;
  logic          cfg_wr;
  logic [WW-1:0] ib, fb_lim;
  logic [FW-1:0] fb;
  logic [WW-1:0] width;
  logic [MW:0]   mask_w;
  fmt_t          fmt;
  logic          en;
  cell_t         chain [QW+1];

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_bits_q  <= 6'd16;
      frac_bits_q <= 5'd16;
      mode_q      <= RND_ZERO;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INT:  int_bits_q  <= pwdata[5:0];
        REG_FRAC: frac_bits_q <= pwdata[4:0];
        REG_MODE: mode_q      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INT:  prdata = 32'(int_bits_q);
      REG_FRAC: prdata = 32'(frac_bits_q);
      REG_MODE: prdata = 32'(mode_q);
      default:  prdata = '0;
    endcase
  end

  // clamped format
  always_comb begin
    if (int_bits_q == '0) begin
      ib = WW'(1);
    end else if (WW'(int_bits_q) > WW'(MW)) begin
      ib = WW'(MW);
    end else begin
      ib = WW'(int_bits_q);
    end
    fb_lim = WW'(MW) - ib;
    fb     = (WW'(frac_bits_q) > fb_lim) ? fb_lim[FW-1:0] : frac_bits_q;
    width  = ib + WW'(fb);
    mask_w = ((MW+1)'(1) << width) - (MW+1)'(1);
  end

  assign fmt.width = width;
  assign fmt.frac  = fb;
  assign fmt.msb   = FW'(width - WW'(1));
  assign fmt.mask  = mask_w[MW-1:0];
  assign fmt.mode  = rnd_e'(mode_q);

  // pipeline
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fpar_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .fmt_i       (fmt),
    .cell_o      (chain[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    fpar_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  fpar_round u_round (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .fmt_i         (fmt),
    .cell_i        (chain[QW]),
    .out_valid_o   (out_valid_o),
    .result_code_o (result_code_o),
    .div_by_zero_o (div_by_zero_o)
  );

  `FPAR_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, out_valid_o && div_by_zero_o, result_code_o == '0)
  `FPAR_ASSERT_IMP(a_upper_zero, clk_i, rst_ni, out_valid_o, (result_code_o & ~fmt.mask) == '0)
  `FPAR_ASSERT_NXT(a_mode_wr, clk_i, rst_ni, cfg_wr && paddr[3:2] == REG_MODE, mode_q == $past(pwdata[1:0]))

endmodule

>>> rtl/core/fpar_front.sv
// ----------------------------------------------------------------------------
// fixed point alu front end
// operand decode, multiply and add/subtract ahead of the divider cells
// ----------------------------------------------------------------------------
module fpar_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic [1:0]                cmd_i,
  input  logic [31:0]               operand_a_i,
  input  logic [31:0]               operand_b_i,
  input  fpar_pkg::fmt_t            fmt_i,
  output fpar_pkg::cell_t           cell_o
);
  import fpar_pkg::*;

  logic          s0_valid_q;
  cmd_e          s0_cmd_q;
  logic          s0_neg_q;
  logic [MW-1:0] s0_va_q, s0_vb_q, s0_ma_q, s0_mb_q;
  logic [MW-1:0] va, vb, ma, mb;
  logic          na, nb;
  logic [2*MW-1:0] prod;
  logic [QW-1:0]   num;
  logic [MW-1:0]   addsub;
  cell_t           cell_d, cell_q;

  assign va = operand_a_i & fmt_i.mask;
  assign vb = operand_b_i & fmt_i.mask;
  assign na = va[fmt_i.msb];
  assign nb = vb[fmt_i.msb];
  assign ma = na ? ((~va + MW'(1)) & fmt_i.mask) : va;
  assign mb = nb ? ((~vb + MW'(1)) & fmt_i.mask) : vb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_cmd_q   <= CMD_ADD;
      s0_neg_q   <= 1'b0;
      s0_va_q    <= '0;
      s0_vb_q    <= '0;
      s0_ma_q    <= '0;
      s0_mb_q    <= '0;
    end else if (en_i) begin
      s0_valid_q <= in_valid_i;
      s0_cmd_q   <= cmd_e'(cmd_i);
      s0_neg_q   <= na ^ nb;
      s0_va_q    <= va;
      s0_vb_q    <= vb;
      s0_ma_q    <= ma;
      s0_mb_q    <= mb;
    end
  end

  assign prod   = s0_ma_q * s0_mb_q;
  assign num    = QW'(s0_ma_q) << fmt_i.frac;
  assign addsub = (s0_cmd_q == CMD_SUB) ? (s0_va_q - s0_vb_q) : (s0_va_q + s0_vb_q);

  always_comb begin
    cell_d.valid   = s0_valid_q;
    cell_d.cmd     = s0_cmd_q;
    cell_d.neg     = s0_neg_q;
    cell_d.rem     = '0;
    cell_d.divisor = s0_mb_q;
    case (s0_cmd_q)
      CMD_MUL: cell_d.nq = prod[QW-1:0];
      CMD_DIV: cell_d.nq = num;
      default: cell_d.nq = QW'(addsub);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/core/fpar_cell.sv
// ----------------------------------------------------------------------------
// fixed point alu divider cell
// one restoring division step per cell, other items pass through
// ----------------------------------------------------------------------------
module fpar_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  fpar_pkg::cell_t cell_i,
  output fpar_pkg::cell_t cell_o
);
  import fpar_pkg::*;

  logic [MW:0] trial;
  logic        fits;
  cell_t       cell_d, cell_q;

  assign trial = {cell_i.rem, cell_i.nq[QW-1]};
  assign fits  = trial >= {1'b0, cell_i.divisor};

  always_comb begin
    cell_d = cell_i;
    if (cell_i.cmd == CMD_DIV) begin
      cell_d.rem = fits ? MW'(trial - {1'b0, cell_i.divisor}) : trial[MW-1:0];
      cell_d.nq  = {cell_i.nq[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/core/fpar_round.sv
// ----------------------------------------------------------------------------
// fixed point alu rounding stage
// rounding decision, sign, wrap and the output register
// ----------------------------------------------------------------------------
module fpar_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  fpar_pkg::fmt_t  fmt_i,
  input  fpar_pkg::cell_t cell_i,
  output logic            out_valid_o,
  output logic [31:0]     result_code_o,
  output logic            div_by_zero_o
);
  import fpar_pkg::*;

  logic [QW-1:0] mul_q, mul_rem, mul_half;
  logic [MW:0]   twice;
  logic [MW-1:0] q_d;
  logic          inexact_d, gt_d, eq_d, neg_d, dz_d;

  logic          t1_valid_q, t1_inexact_q, t1_gt_q, t1_eq_q, t1_neg_q, t1_dz_q;
  logic [MW-1:0] t1_q_q;

  logic          inc;
  logic [MW-1:0] q1, res;
  logic          out_valid_q, dz_q;
  logic [MW-1:0] res_q;

  assign mul_q    = cell_i.nq >> fmt_i.frac;
  assign mul_rem  = cell_i.nq & ~({QW{1'b1}} << fmt_i.frac);
  assign mul_half = (QW'(1) << fmt_i.frac) >> 1;
  assign twice    = {cell_i.rem, 1'b0};

  always_comb begin
    q_d       = cell_i.nq[MW-1:0];
    inexact_d = 1'b0;
    gt_d      = 1'b0;
    eq_d      = 1'b0;
    neg_d     = 1'b0;
    dz_d      = 1'b0;
    case (cell_i.cmd)
      CMD_MUL: begin
        q_d       = mul_q[MW-1:0];
        inexact_d = mul_rem != '0;
        gt_d      = mul_rem > mul_half;
        eq_d      = mul_rem == mul_half;
        neg_d     = cell_i.neg;
      end
      CMD_DIV: begin
        inexact_d = cell_i.rem != '0;
        gt_d      = twice > {1'b0, cell_i.divisor};
        eq_d      = twice == {1'b0, cell_i.divisor};
        neg_d     = cell_i.neg;
        dz_d      = cell_i.divisor == '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q   <= 1'b0;
      t1_q_q       <= '0;
      t1_inexact_q <= 1'b0;
      t1_gt_q      <= 1'b0;
      t1_eq_q      <= 1'b0;
      t1_neg_q     <= 1'b0;
      t1_dz_q      <= 1'b0;
    end else if (en_i) begin
      t1_valid_q   <= cell_i.valid;
      t1_q_q       <= q_d;
      t1_inexact_q <= inexact_d;
      t1_gt_q      <= gt_d;
      t1_eq_q      <= eq_d;
      t1_neg_q     <= neg_d;
      t1_dz_q      <= dz_d;
    end
  end

  always_comb begin
    case (fmt_i.mode)
      RND_NEAREST: inc = t1_inexact_q && (t1_gt_q || (t1_eq_q && t1_q_q[0]));
      RND_POS:     inc = t1_inexact_q && !t1_neg_q;
      RND_NEG:     inc = t1_inexact_q && t1_neg_q;
      default:     inc = 1'b0;
    endcase
  end

  assign q1  = t1_q_q + MW'(inc);
  assign res = t1_dz_q ? '0 : ((t1_neg_q ? (~q1 + MW'(1)) : q1) & fmt_i.mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
      dz_q        <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= t1_valid_q;
      res_q       <= res;
      dz_q        <= t1_dz_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = res_q;
  assign div_by_zero_o = dz_q;

endmodule

>>> test/fixed_point_alu_rounding_top_test.sv
// ----------------------------------------------------------------------------
// fixed point alu testbench
// drives random and corner-case items through the alu under several formats
// and rounding modes, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module fixed_point_alu_rounding_top_test;
  import fpar_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_code_o;
  logic        div_by_zero_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  typedef struct {
    logic [31:0] code;
    logic        dz;
  } alu_res_t;

  alu_res_t    pending_q[$];
  logic [5:0]  cur_int;
  logic [4:0]  cur_frac;
  rnd_e        cur_mode;
  int          errors = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          rx_random = 1'b1;
  localparam int CYCLE_LIMIT = 400000;

  fixed_point_alu_rounding_top u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] round_mag(logic [63:0] q, bit inexact, int cmp, bit neg);
    case (cur_mode)
      RND_NEAREST: if (inexact && (cmp > 0 || (cmp == 0 && q[0]))) q++;
      RND_POS:     if (!neg && inexact) q++;
      RND_NEG:     if (neg && inexact) q++;
      default: ;
    endcase
    return q;
  endfunction

  function automatic alu_res_t alu_predict(cmd_e cmd, logic [31:0] a, logic [31:0] b);
    int unsigned ib, fb, w;
    logic [63:0] mask, va, vb, ma, mb, res, p, q, rem, num, half;
    bit na, nb, neg;
    int cmp;
    alu_res_t r;
    ib = cur_int;
    fb = cur_frac;
    if (ib < 1) ib = 1;
    if (ib > 32) ib = 32;
    if (fb > 32 - ib) fb = 32 - ib;
    w = ib + fb;
    mask = (64'd1 << w) - 1;
    va = a & mask;
    vb = b & mask;
    na = va[w-1];
    nb = vb[w-1];
    ma = na ? ((64'd0 - va) & mask) : va;
    mb = nb ? ((64'd0 - vb) & mask) : vb;
    neg = na != nb;
    r.dz = 1'b0;
    res = '0;
    case (cmd)
      CMD_ADD: res = va + vb;
      CMD_SUB: res = va - vb;
      CMD_MUL: begin
        p = ma * mb;
        q = p >> fb;
        rem = p & ((64'd1 << fb) - 1);
        cmp = 0;
        if (fb > 0) begin
          half = 64'd1 << (fb - 1);
          cmp = rem > half ? 1 : (rem == half ? 0 : -1);
        end
        q = round_mag(q, rem != 0, cmp, neg);
        res = neg ? (64'd0 - q) : q;
      end
      default: begin
        if (mb == 0) r.dz = 1'b1;
        else if (ma != 0) begin
          num = ma << fb;
          q = num / mb;
          rem = num % mb;
          cmp = (rem * 2) > mb ? 1 : ((rem * 2) == mb ? 0 : -1);
          q = round_mag(q, rem != 0, cmp, neg);
          res = neg ? (64'd0 - q) : q;
        end
      end
    endcase
    r.code = 32'(res & mask);
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_INT:  cur_int = val[5:0];
      REG_FRAC: cur_frac = val[4:0];
      default:  cur_mode = rnd_e'(val[1:0]);
    endcase
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_format(int ib, int fb, rnd_e m);
    drain();
    reg_write(REG_INT, ib);
    reg_write(REG_FRAC, fb);
    reg_write(REG_MODE, m);
  endtask

  task automatic send_item(cmd_e cmd, logic [31:0] a, logic [31:0] b, bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 7) : 0;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(alu_predict(cmd, a, b));
  endtask

  initial begin
    int wait_n;
    forever begin
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      wait_n = rx_random ? $urandom_range(0, 7) : 0;
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    alu_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result code %h", $time, result_code_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.code !== result_code_o) begin
          $display("%0t: result_code expected %h actual %h", $time, e.code, result_code_o);
          errors++;
        end
        if (e.dz !== div_by_zero_o) begin
          $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, div_by_zero_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand(int mode);
    case (mode)
      0: return $urandom_range(0, 3);
      1: return 32'hffffffff - $urandom_range(0, 3);
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    rnd_e m;
    for (int k = 0; k < 4; k++) begin
      m = rnd_e'(k);
      set_format(16, 16, m);
      send_item(CMD_ADD, 32'h7fffffff, 32'h00000001, 1'b0);
      send_item(CMD_SUB, 32'h00000000, 32'hffffffff, 1'b0);
      send_item(CMD_MUL, 32'h00018000, 32'h00008000, 1'b0);
      send_item(CMD_MUL, 32'hfffe8000, 32'h00008000, 1'b0);
      send_item(CMD_DIV, 32'h00010000, 32'h00000000, 1'b0);
      send_item(CMD_DIV, 32'h00000000, 32'h00030000, 1'b0);
      send_item(CMD_DIV, 32'hffff0000, 32'h00030000, 1'b0);
    end
    set_format(0, 31, RND_NEAREST);
    send_item(CMD_MUL, 32'hffffffff, 32'hffffffff, 1'b0);
    send_item(CMD_DIV, 32'h80000000, 32'h80000000, 1'b0);
    set_format(63, 31, RND_POS);
    send_item(CMD_MUL, 32'h80000000, 32'h80000000, 1'b0);
    send_item(CMD_DIV, 32'h80000000, 32'h00000003, 1'b0);
  endtask

  task automatic test_random;
    int ib, fb;
    for (int ph = 0; ph < 12; ph++) begin
      ib = (ph % 3 == 0) ? 1 + (ph % 2) * 31 : $urandom_range(0, 40);
      fb = $urandom_range(0, 31);
      set_format(ib, fb, rnd_e'($urandom_range(0, 3)));
      rx_random = (ph % 4 != 3);
      for (int i = 0; i < 70; i++)
        send_item(cmd_e'($urandom_range(0, 3)), rand_operand($urandom_range(0, 5)),
                  rand_operand($urandom_range(0, 5)), ph % 4 != 2);
    end
    rx_random = 1'b1;
  endtask

  task automatic test_back_pressure;
    set_format(12, 8, RND_NEG);
    hold_off = 300;
    for (int i = 0; i < 100; i++)
      send_item(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, 1'b0);
    drain();
    for (int i = 0; i < 20; i++)
      send_item(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, 1'b1);
  endtask

  initial begin
    cur_int = 6'd16;
    cur_frac = 5'd16;
    cur_mode = RND_ZERO;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_back_pressure();
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> fixed_point_alu_rounding_top.f
+incdir+rtl/core
rtl/core/fpar_pkg.sv
rtl/core/fpar_front.sv
rtl/core/fpar_cell.sv
rtl/core/fpar_round.sv
rtl/core/fixed_point_alu_rounding_top.sv
test/fixed_point_alu_rounding_top_test.sv
